/* src/lcgs_pkg.sv */
package lcgs_pkg;

  // Register fields and reset values
  localparam int RowLengthW = 8;
  localparam int RowCountW = 11;
  localparam logic [RowLengthW-1:0] RowLengthReset = 8'd120;
  localparam logic [RowCountW-1:0] RowCountReset = 11'd36;

  // Grid limits
  localparam int MaxRowLengthDefault = 128;
  localparam int MaxRowCountDefault = 1024;
  localparam int MinSide = 3;

  // B3/S23 rule
  localparam int NeighbourW = 4;
  localparam logic [NeighbourW-1:0] BirthCount = 4'd3;
  localparam logic [NeighbourW-1:0] SurviveCount = 4'd2;

  // Configuration port
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam int RegIndexLsb = 2;

  typedef enum logic {
    REG_ROW_LENGTH = 1'b0,
    REG_ROW_COUNT  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic cell_alive;
    logic flush;
  } cell_req_t;

  typedef struct packed {
    logic                  next_alive;
    logic [NeighbourW-1:0] live_neighbours;
    logic                  last_of_frame;
  } gen_req_t;

  // One column slot of the two line buffers
  typedef struct packed {
    logic upper;
    logic middle;
  } line_pair_t;

  // Controls from the raster counters to the window
  typedef struct packed {
    logic shift;
    logic clear;
    logic at_first_col;
    logic at_second_col;
  } window_ctrl_t;

  function automatic logic [1:0] popcount3(input logic [2:0] bits);
    popcount3 = {1'b0, bits[0]} + {1'b0, bits[1]} + {1'b0, bits[2]};
  endfunction

endpackage

/* src/lcgs_line_cell.sv */
module lcgs_line_cell (
  input  logic               clk,
  input  logic               shift,
  input  logic               load,
  input  lcgs_pkg::line_pair_t neighbour,
  input  lcgs_pkg::line_pair_t fresh,
  output lcgs_pkg::line_pair_t held
);
  import lcgs_pkg::*;

  line_pair_t slot;

  // Take the fresh pair at the row's end slot, else pass the neighbor along.
  always_ff @(posedge clk) begin
    if (shift) begin
      slot <= load ? fresh : neighbour;
    end
  end

  assign held = slot;

endmodule

/* src/lcgs_line_chain.sv */
module lcgs_line_chain #(
  parameter int MAX_ROW_LENGTH = lcgs_pkg::MaxRowLengthDefault,
  parameter int LEN_W = $clog2(MAX_ROW_LENGTH + 1)
) (
  input  logic                 clk,
  input  logic                 shift,
  input  logic [LEN_W-1:0]     used_len,
  input  lcgs_pkg::line_pair_t fresh,
  output lcgs_pkg::line_pair_t tap
);
  import lcgs_pkg::*;

  line_pair_t        held [MAX_ROW_LENGTH];
  logic [LEN_W-1:0]  end_slot;

  assign end_slot = used_len - LEN_W'(1);

  for (genvar i = 0; i < MAX_ROW_LENGTH; i++) begin : g_cell
    line_pair_t neighbour;
    if (i == MAX_ROW_LENGTH - 1) begin : g_tail
      assign neighbour = fresh;
    end else begin : g_body
      assign neighbour = held[i+1];
    end

    lcgs_line_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .load      (end_slot == LEN_W'(i)),
      .neighbour (neighbour),
      .fresh     (fresh),
      .held      (held[i])
    );
  end

  assign tap = held[0];

endmodule

/* src/lcgs_window.sv */
module lcgs_window (
  input  logic                                clk,
  input  logic                                rst,
  input  lcgs_pkg::window_ctrl_t              ctrl,
  input  logic [2:0]                          column,
  output logic [lcgs_pkg::NeighbourW-1:0]     live_neighbours,
  output logic                                next_alive
);
  import lcgs_pkg::*;

  logic [8:0] window;
  logic [8:0] window_next;
  logic [2:0] left;
  logic [2:0] mid;
  logic [2:0] right;

  assign window_next = {column, window[8:3]};

  always_comb begin
    left  = ctrl.at_second_col ? 3'b000 : window_next[2:0];
    mid   = window_next[5:3];
    right = ctrl.at_first_col ? 3'b000 : window_next[8:6];
    live_neighbours = NeighbourW'(popcount3(left)) + NeighbourW'(popcount3(right))
                    + NeighbourW'(mid[0]) + NeighbourW'(mid[2]);
    next_alive = (live_neighbours == BirthCount)
              || (mid[1] && live_neighbours == SurviveCount);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      window <= '0;
    end else if (ctrl.shift) begin
      window <= window_next;
    end
  end

endmodule

/* src/life_cell_generation_stencil_top.sv */
// Streaming Life stencil, rule B3/S23. Send one generation as a raster stream of
// cell requests (row_count rows of row_length cells), then row_length+1 flush
// requests. Each accepted request yields at most one next-generation cell,
// emitted one row plus one cell behind its input, with its live-neighbor count
// and a last_of_frame mark on the final cell; cells off the grid count as dead.
// The block takes one request per clock while cell_stall is low: the line
// buffers are a chain of shift cells whose length follows row_length, so every
// accepted request moves the chain one slot, and a two-entry output buffer lets
// input keep flowing while one result waits. Each result is registered.
// Register writes (row_length at 0x0, row_count at 0x4, both saturated to 3..max)
// restart the frame; write them only while the block is idle.
module life_cell_generation_stencil_top #(
  parameter int MAX_ROW_LENGTH = lcgs_pkg::MaxRowLengthDefault,
  parameter int MAX_ROW_COUNT  = lcgs_pkg::MaxRowCountDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cell_valid,
  output logic                         cell_stall,
  input  lcgs_pkg::cell_req_t          cell_req,
  output logic                         gen_valid,
  input  logic                         gen_stall,
  output lcgs_pkg::gen_req_t           gen,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcgs_pkg::AddrW-1:0]   paddr,
  input  logic [lcgs_pkg::DataW-1:0]   pwdata,
  output logic [lcgs_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import lcgs_pkg::*;

  localparam int LEN_W  = $clog2(MAX_ROW_LENGTH + 1);
  localparam int LCMP_W = (LEN_W > RowLengthW) ? LEN_W : RowLengthW;
  localparam int CNT_W  = $clog2(MAX_ROW_COUNT + 1);
  localparam int CCMP_W = (CNT_W > RowCountW) ? CNT_W : RowCountW;
  localparam int COL_W  = $clog2(MAX_ROW_LENGTH);
  localparam int ROW_W  = $clog2(MAX_ROW_COUNT + 2);
  localparam int RCMP_W = ROW_W + 1;
  localparam int EMIT_W = $clog2(MAX_ROW_LENGTH * MAX_ROW_COUNT + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [RowLengthW-1:0] row_length, row_length_next;
  logic [RowCountW-1:0]  row_count, row_count_next;
  logic [LCMP_W-1:0]     len_wide;
  logic [CCMP_W-1:0]     cnt_wide;
  logic [LEN_W-1:0]      used_len, used_len_next;
  logic [CNT_W-1:0]      used_rows, used_rows_next;
  logic [EMIT_W-1:0]     frame_cells, frame_cells_next;
  logic                  cfg_write;
  reg_index_t            cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[RegIndexLsb]);

  always_comb begin
    row_length_next = row_length;
    row_count_next  = row_count;
    if (rst) begin
      row_length_next = RowLengthReset;
      row_count_next  = RowCountReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_LENGTH: row_length_next = pwdata[RowLengthW-1:0];
        REG_ROW_COUNT:  row_count_next  = pwdata[RowCountW-1:0];
        default: ;
      endcase
    end

    // Saturate to the usable range; the frame size follows from both.
    len_wide = LCMP_W'(row_length_next);
    if (len_wide < LCMP_W'(MinSide)) len_wide = LCMP_W'(MinSide);
    if (len_wide > LCMP_W'(MAX_ROW_LENGTH)) len_wide = LCMP_W'(MAX_ROW_LENGTH);
    cnt_wide = CCMP_W'(row_count_next);
    if (cnt_wide < CCMP_W'(MinSide)) cnt_wide = CCMP_W'(MinSide);
    if (cnt_wide > CCMP_W'(MAX_ROW_COUNT)) cnt_wide = CCMP_W'(MAX_ROW_COUNT);
    used_len_next    = len_wide[LEN_W-1:0];
    used_rows_next   = cnt_wide[CNT_W-1:0];
    frame_cells_next = EMIT_W'(used_len_next) * EMIT_W'(used_rows_next);
  end

  always_ff @(posedge clk) begin
    row_length  <= row_length_next;
    row_count   <= row_count_next;
    used_len    <= used_len_next;
    used_rows   <= used_rows_next;
    frame_cells <= frame_cells_next;
  end

  always_comb begin
    unique case (cfg_index)
      REG_ROW_LENGTH: prdata = DataW'(row_length);
      REG_ROW_COUNT:  prdata = DataW'(row_count);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Raster position and masks
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;
  logic [EMIT_W-1:0] emitted;
  logic [RCMP_W-1:0] row_wide;
  logic [RCMP_W-1:0] rows_wide;
  logic              accept;
  logic              in_grid, middle_ok, upper_ok;
  logic              live_in, emit, last, row_end;
  line_pair_t        tap, fresh;
  window_ctrl_t      wctrl;
  logic [NeighbourW-1:0] count;
  logic              next_alive;

  assign accept    = cell_valid && !cell_stall;
  assign row_wide  = RCMP_W'(row);
  assign rows_wide = RCMP_W'(used_rows);

  always_comb begin
    // Current row inside the grid, and the rows held in the two line buffers.
    in_grid   = row_wide < rows_wide;
    middle_ok = (row_wide >= RCMP_W'(1)) && (row_wide < rows_wide + RCMP_W'(1));
    upper_ok  = (row_wide >= RCMP_W'(2)) && (row_wide < rows_wide + RCMP_W'(2));
    live_in   = cell_req.cell_alive && !cell_req.flush && in_grid;

    // Push the live bit into the middle line; age the middle line into the upper.
    fresh.upper  = tap.middle;
    fresh.middle = live_in;

    // Drop results until the window has the first cell centered.
    emit    = (row_wide >= RCMP_W'(2)) || (row_wide == RCMP_W'(1) && column != '0);
    last    = (emitted + EMIT_W'(1)) >= frame_cells;
    row_end = (LEN_W'(column) + LEN_W'(1)) == used_len;

    wctrl.shift         = accept;
    wctrl.clear         = cfg_write || (accept && emit && last);
    wctrl.at_first_col  = column == COL_W'(0);
    wctrl.at_second_col = column == COL_W'(1);
  end

  // Counters restart on a register write and after the last cell of the frame.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      column  <= '0;
      row     <= '0;
      emitted <= '0;
    end else if (accept) begin
      if (emit && last) begin
        column  <= '0;
        row     <= '0;
        emitted <= '0;
      end else begin
        if (emit) begin
          emitted <= emitted + EMIT_W'(1);
        end
        if (row_end) begin
          column <= '0;
          row    <= row + ROW_W'(1);
        end else begin
          column <= column + COL_W'(1);
        end
      end
    end
  end

  lcgs_line_chain #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .LEN_W          (LEN_W)
  ) u_lines (
    .clk      (clk),
    .shift    (accept),
    .used_len (used_len),
    .fresh    (fresh),
    .tap      (tap)
  );

  lcgs_window u_window (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (wctrl),
    .column          ({live_in, tap.middle && middle_ok, tap.upper && upper_ok}),
    .live_neighbours (count),
    .next_alive      (next_alive)
  );

  // ---------------------------------------------------------------------------
  // Output register plus skid entry
  // ---------------------------------------------------------------------------
  gen_req_t result;
  gen_req_t skid;
  logic     skid_valid;
  logic     push, take;

  assign result.next_alive      = next_alive;
  assign result.live_neighbours = count;
  assign result.last_of_frame   = last;

  assign push       = accept && emit;
  assign take       = gen_valid && !gen_stall;
  assign cell_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // Hold the input; advance the skid entry once the output is taken.
        if (take) begin
          gen        <= skid;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (!gen_valid || take) begin
          gen       <= result;
          gen_valid <= 1'b1;
        end else begin
          skid       <= result;
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        gen_valid <= 1'b0;
      end
    end
  end

endmodule
